@@ hdl/lrrb_pkg.sv @@
// Shared types and constants of the lapping record ring buffer.
// Depends on nothing; lrrb_front, lrrb_back and the top level import it.
`default_nettype none
package lrrb_pkg;

	localparam int RING_DEPTH_DEF = 4096;
	localparam int MAX_RECORD_DEF = 64;

	localparam int CFG_W = 13;
	localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_OPEN   = 2'd2;
	localparam logic [1:0] OP_RESYNC = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOTHING    = 3'd1;
	localparam logic [2:0] ST_BEHIND     = 3'd2;
	localparam logic [2:0] ST_INVALID    = 3'd3;
	localparam logic [2:0] ST_NOT_OPENED = 3'd4;
	localparam logic [2:0] ST_DROPPED    = 3'd5;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  data_byte;
		logic        record_last;
		logic        stamp_on;
		logic [5:0]  stamp_pos;
		logic [63:0] stamp_value;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic [6:0] record_length;
		logic       last;
	} result_t;

	// Decoded command handed from the front end to the engine
	typedef struct packed {
		logic  is_write;
		logic  is_read;
		logic  is_open;
		item_t item;
	} cmd_t;

endpackage
`default_nettype wire

@@ hdl/lrrb_ram.sv @@
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
`default_nettype none
module lrrb_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ hdl/lrrb_front.sv @@
// Front end: accepts items, decodes the opcode, queues commands for the engine.
// Depends on lrrb_pkg.
`default_nettype none
module lrrb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire lrrb_pkg::item_t item,
	output logic               cmd_valid,
	input  wire logic          cmd_pop,
	output lrrb_pkg::cmd_t     cmd
);
	import lrrb_pkg::*;

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec.is_write = (item.opcode == OP_WRITE);
		dec.is_read  = (item.opcode == OP_READ);
		dec.is_open  = (item.opcode == OP_OPEN);
		dec.item     = item;
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign pop        = cmd_pop && cmd_valid;
	assign cmd        = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/lrrb_back.sv @@
// Engine: staging, record commit, record read and reader sync, plus result register.
// Depends on lrrb_pkg and lrrb_ram.
`default_nettype none
module lrrb_back #(
	parameter int RING_DEPTH = lrrb_pkg::RING_DEPTH_DEF,
	parameter int MAX_RECORD = lrrb_pkg::MAX_RECORD_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic [lrrb_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                   cmd_valid,
	output logic                        cmd_pop,
	input  wire lrrb_pkg::cmd_t         cmd,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output lrrb_pkg::result_t           result
);
	import lrrb_pkg::*;

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int CW  = AW + 1;
	localparam int SW  = $clog2(MAX_RECORD);
	localparam int CNW = $clog2(MAX_RECORD + 1);
	localparam int DW  = AW + 3;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EMIT = 4'd1;
	localparam logic [3:0] S_CL0  = 4'd2;
	localparam logic [3:0] S_CL1  = 4'd3;
	localparam logic [3:0] S_CP   = 4'd4;
	localparam logic [3:0] S_RH1  = 4'd5;
	localparam logic [3:0] S_RH2  = 4'd6;
	localparam logic [3:0] S_RCHK = 4'd7;
	localparam logic [3:0] S_RPAY = 4'd8;

	logic [3:0]       state_q;
	logic [CFG_W-1:0] cap_cfg_q;
	logic [CNW-1:0]   stage_cnt_q;
	logic             stage_ovf_q;
	logic [AW-1:0]    wo_q;
	logic [31:0]      wg_q;
	logic [AW-1:0]    ro_q;
	logic [31:0]      rg_q;
	logic [2:0]       rs_q;
	logic [2:0]       st_q;
	logic [AW-1:0]    ptr_q;
	logic [31:0]      gen_q;
	logic             wrap_q;
	logic [15:0]      size_q;
	logic [SW-1:0]    k_q;
	logic             stamp_on_q;
	logic [5:0]       soff_q;
	logic [63:0]      sval_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [CW-1:0]    cap;
	logic [CW-1:0]    p1;
	logic             ptr_wrap;
	logic [AW-1:0]    ptr_nxt;
	logic             can_emit;
	logic             k_last;
	logic             same_pos;

	logic             ring_we;
	logic [7:0]       ring_wdata;
	logic             ring_re;
	logic [AW-1:0]    ring_raddr;
	logic [7:0]       ring_rdata;
	logic             stg_we;
	logic             stg_re;
	logic [SW-1:0]    stg_raddr;
	logic [7:0]       stg_rdata;
	logic             emit;
	result_t          emit_val;

	logic [CNW-1:0]   cnt_n;
	logic             ovf_n;
	logic             drop;

	logic             in_win;
	logic [7:0]       kk;
	logic [2:0]       sidx;
	logic [63:0]      sh;

	logic             bad_size;
	logic [7:0]       rec;
	logic [31:0]      dg;
	logic signed [DW-1:0] dof;
	logic signed [DW-1:0] ndof;
	logic signed [DW-1:0] crec;
	logic signed [DW-1:0] recs;
	logic [2:0]       chk;

	// effective capacity, clamped to [2*MAX_RECORD, RING_DEPTH]
	always_comb begin
		if (32'(cap_cfg_q) > 32'(RING_DEPTH)) begin
			cap = CW'(RING_DEPTH);
		end else if (32'(cap_cfg_q) < 32'(2 * MAX_RECORD)) begin
			cap = CW'(2 * MAX_RECORD);
		end else begin
			cap = CW'(cap_cfg_q);
		end
	end

	assign p1       = {1'b0, ptr_q} + CW'(1);
	assign ptr_wrap = (p1 >= cap);
	assign ptr_nxt  = ptr_wrap ? '0 : p1[AW-1:0];
	assign can_emit = !out_valid_q || !result_stall;
	assign k_last   = ((16'(k_q) + 16'd1) == size_q);
	assign same_pos = (ro_q == wo_q) && (rg_q == wg_q);
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;

	// staging of the incoming byte
	always_comb begin
		ovf_n = stage_ovf_q;
		cnt_n = stage_cnt_q;
		if (stage_cnt_q < CNW'(MAX_RECORD)) begin
			cnt_n = stage_cnt_q + CNW'(1);
		end else begin
			ovf_n = 1'b1;
		end
		drop = ovf_n || (cmd.item.stamp_on &&
			((8'(cmd.item.stamp_pos) + 8'd8) > 8'(cnt_n)));
	end

	// stamp overlay window
	always_comb begin
		kk     = 8'(k_q);
		in_win = stamp_on_q && (kk >= 8'(soff_q)) && (kk < (8'(soff_q) + 8'd8));
		sidx   = 3'(kk - 8'(soff_q));
		sh     = sval_q >> {sidx, 3'b000};
	end

	// reader position check
	always_comb begin
		bad_size = (size_q == 16'd0) || (size_q > 16'(MAX_RECORD));
		rec      = bad_size ? 8'(MAX_RECORD + 2) : (8'(size_q) + 8'd2);
		dg       = wg_q - rg_q;
		dof      = DW'(wo_q) - DW'(ro_q);
		ndof     = DW'(ro_q) - DW'(wo_q);
		recs     = DW'(rec);
		crec     = DW'(cap) - DW'(rec);
		if ({1'b0, wo_q} >= cap || {1'b0, ro_q} >= cap) begin
			chk = ST_INVALID;
		end else if (dg == 32'd0) begin
			if (dof == '0) begin
				chk = ST_NOTHING;
			end else if (dof <= $signed(DW'(1))) begin
				chk = ST_INVALID;
			end else if (dof > crec) begin
				chk = ST_BEHIND;
			end else begin
				chk = ST_OK;
			end
		end else if (dg == 32'd1) begin
			if (ndof > crec) begin
				chk = ST_INVALID;
			end else if (ndof < recs) begin
				chk = ST_BEHIND;
			end else begin
				chk = ST_OK;
			end
		end else if (dg[31]) begin
			chk = ST_INVALID;
		end else begin
			chk = ST_BEHIND;
		end
	end

	// memory controls and result selection
	always_comb begin
		ring_we    = 1'b0;
		ring_wdata = '0;
		ring_re    = 1'b0;
		ring_raddr = ptr_nxt;
		stg_we     = 1'b0;
		stg_re     = 1'b0;
		stg_raddr  = SW'({1'b0, k_q} + 1'b1);
		emit       = 1'b0;
		emit_val   = '{status: st_q, out_byte: 8'd0, record_length: 7'd0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.is_write && !ovf_n) begin
					stg_we = (stage_cnt_q < CNW'(MAX_RECORD));
				end
				if (cmd_valid && cmd.is_write && ovf_n == stage_ovf_q) begin
					stg_we = (stage_cnt_q < CNW'(MAX_RECORD));
				end
				if (cmd_valid && cmd.is_read && rs_q == ST_OK && !same_pos &&
					{1'b0, ro_q} < cap) begin
					ring_re    = 1'b1;
					ring_raddr = ro_q;
				end
			end
			S_EMIT: begin
				emit = 1'b1;
			end
			S_CL0: begin
				ring_we    = 1'b1;
				ring_wdata = size_q[7:0];
			end
			S_CL1: begin
				ring_we    = 1'b1;
				ring_wdata = size_q[15:8];
				stg_re     = 1'b1;
				stg_raddr  = '0;
			end
			S_CP: begin
				ring_we    = 1'b1;
				ring_wdata = in_win ? sh[7:0] : stg_rdata;
				stg_re     = !k_last;
			end
			S_RH1, S_RH2: begin
				ring_re = 1'b1;
			end
			S_RCHK: begin
			end
			S_RPAY: begin
				emit     = 1'b1;
				emit_val = '{status: ST_OK, out_byte: ring_rdata,
					record_length: 7'(size_q), last: k_last};
				ring_re  = can_emit && !k_last;
			end
			default: begin
			end
		endcase
	end

	lrrb_ram #(.DATA_W(8), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ptr_q),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	lrrb_ram #(.DATA_W(8), .DEPTH(MAX_RECORD)) u_stage (
		.clk   (clk),
		.we    (stg_we),
		.waddr (stage_cnt_q[SW-1:0]),
		.wdata (cmd.item.data_byte),
		.re    (stg_re),
		.raddr (stg_raddr),
		.rdata (stg_rdata)
	);

	// result register
	always_ff @(posedge clk) begin
		if (emit && can_emit) begin
			out_q <= emit_val;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.is_write) begin
					size_q     <= 16'(cnt_n);
					stamp_on_q <= cmd.item.stamp_on;
					soff_q     <= cmd.item.stamp_pos;
					sval_q     <= cmd.item.stamp_value;
					ptr_q      <= ({1'b0, wo_q} >= cap) ? '0 : wo_q;
					gen_q      <= wg_q;
				end else if (cmd_valid && cmd.is_read) begin
					ptr_q  <= ro_q;
					wrap_q <= 1'b0;
				end
			end
			S_CL0, S_CL1: begin
				ptr_q <= ptr_nxt;
				gen_q <= gen_q + 32'(ptr_wrap);
				k_q   <= '0;
			end
			S_CP: begin
				ptr_q <= ptr_nxt;
				gen_q <= gen_q + 32'(ptr_wrap);
				k_q   <= SW'({1'b0, k_q} + 1'b1);
			end
			S_RH1: begin
				size_q[7:0] <= ring_rdata;
				ptr_q       <= ptr_nxt;
				wrap_q      <= wrap_q | ptr_wrap;
			end
			S_RH2: begin
				size_q[15:8] <= ring_rdata;
				ptr_q        <= ptr_nxt;
				wrap_q       <= wrap_q | ptr_wrap;
				k_q          <= '0;
			end
			S_RPAY: begin
				if (can_emit) begin
					ptr_q  <= ptr_nxt;
					wrap_q <= wrap_q | ptr_wrap;
					k_q    <= SW'({1'b0, k_q} + 1'b1);
				end
			end
			S_EMIT, S_RCHK: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_cfg_q   <= CAP_RESET;
			stage_cnt_q <= '0;
			stage_ovf_q <= 1'b0;
			wo_q        <= '0;
			wg_q        <= '0;
			ro_q        <= '0;
			rg_q        <= '0;
			rs_q        <= ST_NOT_OPENED;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_cfg_q <= cfg_data;
			end
			if (emit && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.is_write) begin
							if (!cmd.item.record_last) begin
								stage_cnt_q <= cnt_n;
								stage_ovf_q <= ovf_n;
							end else begin
								stage_cnt_q <= '0;
								stage_ovf_q <= 1'b0;
								if (drop) begin
									st_q    <= ST_DROPPED;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_CL0;
								end
							end
						end else if (cmd.is_read) begin
							if (rs_q != ST_OK) begin
								st_q    <= rs_q;
								state_q <= S_EMIT;
							end else if (same_pos) begin
								st_q    <= ST_NOTHING;
								state_q <= S_EMIT;
							end else if ({1'b0, ro_q} >= cap) begin
								rs_q    <= ST_INVALID;
								st_q    <= ST_INVALID;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RH1;
							end
						end else begin
							// open always syncs; reset syncs only a reader left behind
							if (cmd.is_open || rs_q == ST_BEHIND) begin
								ro_q <= wo_q;
								rg_q <= wg_q;
								rs_q <= ST_OK;
								st_q <= ST_OK;
							end else begin
								st_q <= rs_q;
							end
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				S_CL0: begin
					state_q <= S_CL1;
				end
				S_CL1: begin
					state_q <= S_CP;
				end
				S_CP: begin
					if (k_last) begin
						wo_q    <= ptr_nxt;
						wg_q    <= gen_q + 32'(ptr_wrap);
						st_q    <= ST_OK;
						state_q <= S_EMIT;
					end
				end
				S_RH1: begin
					state_q <= S_RH2;
				end
				S_RH2: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (bad_size) begin
						rs_q    <= (chk == ST_BEHIND) ? ST_BEHIND : ST_INVALID;
						st_q    <= (chk == ST_BEHIND) ? ST_BEHIND : ST_INVALID;
						state_q <= S_EMIT;
					end else if (chk == ST_OK) begin
						state_q <= S_RPAY;
					end else begin
						rs_q    <= (chk == ST_NOTHING) ? ST_INVALID : chk;
						st_q    <= (chk == ST_NOTHING) ? ST_INVALID : chk;
						state_q <= S_EMIT;
					end
				end
				S_RPAY: begin
					if (can_emit && k_last) begin
						ro_q    <= ptr_nxt;
						rg_q    <= rg_q + 32'(wrap_q | ptr_wrap);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
endmodule
`default_nettype wire

@@ hdl/lapping_record_ring_buffer.sv @@
// Top level of the lapping record ring buffer: front end, engine and result register.
// Depends on lrrb_pkg, lrrb_front, lrrb_back (which holds the lrrb_ram instances).
//
// Usage:
//   item channel (item_valid / item_stall / item): one transfer per command.
//     Opcode write stages one payload byte; the byte marked record_last commits
//     or drops the record. Read gets one record; open resyncs the reader, reset if behind.
//   result channel (result_valid / result_stall / result): a read of a record
//     gives one transfer per payload byte; every other result-bearing command
//     gives one transfer; last marks the final transfer of a command.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes ring_capacity; ready
//     is always high. Write it only while the block is idle.
// Steps: a staged byte is written in the idle state. A commit writes the two size bytes
//   (CL0, CL1) and copies the payload (CP); a read fetches the size bytes (RH1, RH2),
//   checks the position (RCHK), then streams the payload (RPAY) or emits the failure.
//   One ring byte per cycle unless results stall; a two-entry queue decouples items.
// Reset: empty staging, write and read positions at zero, reader not opened,
//   capacity 4096. Ring contents are undefined until written; no clearing pass.
// Stall: a stalled result holds in the result register; the engine waits and
//   the queue fills, then item_stall rises.
`default_nettype none
module lapping_record_ring_buffer #(
	parameter int RING_DEPTH = lrrb_pkg::RING_DEPTH_DEF,
	parameter int MAX_RECORD = lrrb_pkg::MAX_RECORD_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire lrrb_pkg::item_t            item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output lrrb_pkg::result_t               result,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lrrb_pkg::CFG_W-1:0] cfg_data
);
	import lrrb_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// capacity register accepts a transfer every cycle
	assign cfg_ready = 1'b1;

	// accept and decode; hold up to two commands
	lrrb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	// execute one command at a time against the ring
	lrrb_back #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_RECORD (MAX_RECORD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);
endmodule
`default_nettype wire
